### design/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (rst_n low).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/stc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the sphere cell triangulator.
// No dependencies; the top level, CORDIC cell, output stage and checker refer to it by scoped names.
package stc_pkg;

    localparam int DIV_STEPS    = 33;
    localparam int CORDIC_STEPS = 16;
    localparam int LANES        = 4;
    localparam int PIPE_DEPTH   = DIV_STEPS + CORDIC_STEPS + 3;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_RADIUS        = 2'd0;
    localparam logic [1:0] REG_BAND_COUNT    = 2'd1;
    localparam logic [1:0] REG_SEGMENT_COUNT = 2'd2;

    // Vertex slots: A is the first triangle, B the second
    localparam logic [2:0] SLOT_A0 = 3'd0;
    localparam logic [2:0] SLOT_A1 = 3'd1;
    localparam logic [2:0] SLOT_A2 = 3'd2;
    localparam logic [2:0] SLOT_B0 = 3'd3;
    localparam logic [2:0] SLOT_B1 = 3'd4;
    localparam logic [2:0] SLOT_B2 = 3'd5;

    typedef struct packed {
        logic valid;
        logic first;
        logic second;
    } side_t;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } vtx_t;

    // Arctangent of 2^-step as a fraction of a turn (2^32 = one turn)
    function automatic logic signed [32:0] atan_turn(input int step);
        logic signed [32:0] a;
        case (step)
            0:       a = 33'sh020000000;
            1:       a = 33'sh012E4051E;
            2:       a = 33'sh009FB385B;
            3:       a = 33'sh0051111D4;
            4:       a = 33'sh0028B0D43;
            5:       a = 33'sh00145D7E1;
            6:       a = 33'sh000A2F61E;
            7:       a = 33'sh000517C55;
            8:       a = 33'sh00028BE53;
            9:       a = 33'sh000145F2F;
            10:      a = 33'sh0000A2F98;
            11:      a = 33'sh0000517CC;
            12:      a = 33'sh000028BE6;
            13:      a = 33'sh0000145F3;
            14:      a = 33'sh00000A2FA;
            default: a = 33'sh00000517D;
        endcase
        return a;
    endfunction

    // Round half up by sh bits, then saturate to 16 bits signed
    function automatic logic signed [15:0] round_sat16(input logic signed [49:0] v,
                                                       input int unsigned sh);
        logic signed [49:0] r;
        logic signed [15:0] o;
        r = (v + (50'sd1 <<< (sh - 1))) >>> sh;
        if (r > 50'sd32767) begin
            o = 16'sh7FFF;
        end else if (r < -50'sd32768) begin
            o = 16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

endpackage

### design/sphere_cell_triangulator.sv
`timescale 1ns / 1ps
// An input cell passes the divider and CORDIC cells, then the sin/cos, product and corner
// registers. Throughput is set by the output channel, which moves one vertex per transfer:
// six for a cell with both triangles, three at a pole, none for a cell that yields nothing.
// The divider and CORDIC chains take a new cell every cycle but hold while a finished cell waits.
// Reset (aresetn low, synchronous) empties the pipeline and restores radius 1.0, 16 x 16.
module sphere_cell_triangulator #(
    parameter int MAX_BANDS    = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // band[8:0], segment[17:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // x_coord[15:0], y_coord[31:16], z_coord[47:32],
                                    // vertex_slot[50:48]
    output logic        m_tlast,    // last_vertex
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DS = stc_pkg::DIV_STEPS;
    localparam int CS = stc_pkg::CORDIC_STEPS;
    localparam int NL = stc_pkg::LANES;
    localparam int PD = stc_pkg::PIPE_DEPTH;

    // Configuration registers
    logic [14:0] radius_reg;
    logic [8:0]  band_count_reg;
    logic [8:0]  segment_count_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg        <= 15'd256;
            band_count_reg    <= 9'd16;
            segment_count_reg <= 9'd16;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                stc_pkg::REG_RADIUS:        radius_reg        <= pwdata[14:0];
                stc_pkg::REG_BAND_COUNT:    band_count_reg    <= pwdata[8:0];
                stc_pkg::REG_SEGMENT_COUNT: segment_count_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            stc_pkg::REG_RADIUS:        prdata = {17'd0, radius_reg};
            stc_pkg::REG_BAND_COUNT:    prdata = {23'd0, band_count_reg};
            stc_pkg::REG_SEGMENT_COUNT: prdata = {23'd0, segment_count_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Counts clamped to their maximum
    logic [8:0] nb;
    logic [8:0] ns;

    assign nb = ({23'd0, band_count_reg} > 32'(MAX_BANDS)) ? 9'(MAX_BANDS) : band_count_reg;
    assign ns = ({23'd0, segment_count_reg} > 32'(MAX_SEGMENTS)) ?
                9'(MAX_SEGMENTS) : segment_count_reg;

    // Input decode
    logic [8:0]           bi;
    logic [8:0]           sj;
    logic                 in_range;
    logic                 adv;
    stc_pkg::side_t       side_in;
    stc_pkg::side_t       side_reg [PD];
    logic                 out_can_load;
    logic [40:0]          dvd [NL];

    assign bi = s_tdata[8:0];
    assign sj = s_tdata[17:9];

    always_comb begin
        in_range = (nb != 9'd0) && (ns != 9'd0) && (bi != 9'd0) && (sj != 9'd0) &&
                   (bi <= nb) && (sj <= ns) && ((bi < nb) || (bi > 9'd1));
        side_in.valid  = s_tvalid && in_range;
        side_in.first  = bi < nb;
        side_in.second = bi > 9'd1;
        // angle = round(k * 2^31 / N) for polar, round(k * 2^32 / S) for azimuth
        dvd[0] = {1'b0, bi - 9'd1, 31'(nb >> 1)};
        dvd[1] = {1'b0, bi, 31'(nb >> 1)};
        dvd[2] = {sj - 9'd1, 32'(ns >> 1)};
        dvd[3] = {sj, 32'(ns >> 1)};
    end

    // Whole pipeline moves together; hold while the last stage waits for the output stage
    assign adv      = !side_reg[PD-1].valid || out_can_load;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PD; i++) begin
                side_reg[i] <= '0;
            end
        end else if (adv) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < PD; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Lanes: polar t0, polar t1, azimuth a0, azimuth a1
    logic [8:0]         rem_w  [NL][DS+1];
    logic [32:0]        acc_w  [NL][DS+1];
    logic signed [33:0] x_w    [NL][CS+1];
    logic signed [33:0] y_w    [NL][CS+1];
    logic signed [32:0] z_w    [NL][CS+1];
    logic [1:0]         q_w    [NL][CS+1];

    for (genvar l = 0; l < NL; l++) begin : g_lane
        logic [8:0] lane_div;

        assign lane_div    = (l < 2) ? nb : ns;
        assign rem_w[l][0] = {1'b0, dvd[l][40:33]};
        assign acc_w[l][0] = dvd[l][32:0];

        for (genvar c = 0; c < DS; c++) begin : g_div
            stc_div_cell u_div (
                .aclk    (aclk),
                .en      (adv),
                .divisor (lane_div),
                .rem_in  (rem_w[l][c]),
                .acc_in  (acc_w[l][c]),
                .rem_out (rem_w[l][c+1]),
                .acc_out (acc_w[l][c+1])
            );
        end

        // Angle is taken mod one turn; top two bits pick the quadrant
        assign x_w[l][0] = stc_pkg::CORDIC_GAIN;
        assign y_w[l][0] = '0;
        assign z_w[l][0] = {3'b000, acc_w[l][DS][29:0]};
        assign q_w[l][0] = acc_w[l][DS][31:30];

        for (genvar c = 0; c < CS; c++) begin : g_cordic
            stc_cordic_cell #(.STEP(c)) u_cordic (
                .aclk     (aclk),
                .en       (adv),
                .x_in     (x_w[l][c]),
                .y_in     (y_w[l][c]),
                .z_in     (z_w[l][c]),
                .quad_in  (q_w[l][c]),
                .x_out    (x_w[l][c+1]),
                .y_out    (y_w[l][c+1]),
                .z_out    (z_w[l][c+1]),
                .quad_out (q_w[l][c+1])
            );
        end
    end

    // Quadrant fold and rounding to Q1.15
    logic signed [33:0] cq [NL];
    logic signed [33:0] sq [NL];
    logic signed [15:0] cos_reg [NL];
    logic signed [15:0] sin_reg [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            case (q_w[l][CS])
                2'd0: begin
                    cq[l] = x_w[l][CS];
                    sq[l] = y_w[l][CS];
                end
                2'd1: begin
                    cq[l] = -y_w[l][CS];
                    sq[l] = x_w[l][CS];
                end
                2'd2: begin
                    cq[l] = -x_w[l][CS];
                    sq[l] = -y_w[l][CS];
                end
                default: begin
                    cq[l] = y_w[l][CS];
                    sq[l] = -x_w[l][CS];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < NL; l++) begin
                cos_reg[l] <= stc_pkg::round_sat16(50'(cq[l]), 15);
                sin_reg[l] <= stc_pkg::round_sat16(50'(sq[l]), 15);
            end
        end
    end

    // Radius products: R sin t kept exact, R cos t rounded to Q7.8
    logic signed [15:0] r_s;
    logic signed [31:0] rs_reg  [2];
    logic signed [15:0] yv_reg  [2];
    logic signed [15:0] ac_reg  [2];
    logic signed [15:0] as_reg  [2];
    logic signed [31:0] rs_next [2];
    logic signed [31:0] rc_next [2];

    assign r_s = {1'b0, radius_reg};

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            rs_next[t] = 32'(r_s) * 32'(sin_reg[t]);
            rc_next[t] = 32'(r_s) * 32'(cos_reg[t]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t < 2; t++) begin
                rs_reg[t] <= rs_next[t];
                yv_reg[t] <= stc_pkg::round_sat16(50'(rc_next[t]), 15);
                ac_reg[t] <= cos_reg[t+2];
                as_reg[t] <= sin_reg[t+2];
            end
        end
    end

    // Corners: v0 (t0,a0), v1 (t1,a0), v2 (t0,a1), v3 (t1,a1)
    stc_pkg::vtx_t [3:0] vtx_reg;
    logic signed [49:0]  px [4];
    logic signed [49:0]  pz [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            px[k] = 50'(rs_reg[k % 2]) * 50'(as_reg[k / 2]);
            pz[k] = 50'(rs_reg[k % 2]) * 50'(ac_reg[k / 2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                vtx_reg[k].x <= stc_pkg::round_sat16(px[k], 30);
                vtx_reg[k].y <= yv_reg[k % 2];
                vtx_reg[k].z <= stc_pkg::round_sat16(pz[k], 30);
            end
        end
    end

    stc_vertex_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (side_reg[PD-1].valid),
        .in_vtx    (vtx_reg),
        .in_first  (side_reg[PD-1].first),
        .in_second (side_reg[PD-1].second),
        .can_load  (out_can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### design/stc_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: brings in one dividend bit and retires one quotient bit.
// Depends on nothing; chained by the top level into a full-rate divider that holds while en is low.
module stc_div_cell (
    input  logic        aclk,
    input  logic        en,
    input  logic [8:0]  divisor,
    input  logic [8:0]  rem_in,
    input  logic [32:0] acc_in,
    output logic [8:0]  rem_out,
    output logic [32:0] acc_out
);

    logic [9:0]  trial;
    logic        ge;
    logic [9:0]  diff;
    logic [8:0]  rem_next;
    logic [32:0] acc_next;

    // acc carries the unused dividend bits at the top and the quotient at the bottom
    always_comb begin
        trial    = {rem_in, acc_in[32]};
        ge       = trial >= {1'b0, divisor};
        diff     = trial - {1'b0, divisor};
        rem_next = ge ? diff[8:0] : trial[8:0];
        acc_next = {acc_in[31:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= rem_next;
            acc_out <= acc_next;
        end
    end

endmodule

### design/stc_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation cell (fixed step index) with the quadrant riding alongside.
// Depends on stc_pkg for the arctangent table.
module stc_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [32:0] z_in,
    input  logic [1:0]         quad_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [32:0] z_out,
    output logic [1:0]         quad_out
);

    localparam logic signed [32:0] ATAN = stc_pkg::atan_turn(STEP);

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [32:0] z_next;

    always_comb begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!z_in[32]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            quad_out <= quad_in;
        end
    end

endmodule

### design/stc_vertex_out.sv
`timescale 1ns / 1ps
// Output stage: holds the four corners of one cell and sends its triangles vertex by vertex.
// Depends on stc_pkg for the vertex type and slot codes.
module stc_vertex_out (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  stc_pkg::vtx_t [3:0]     in_vtx,
    input  logic                    in_first,
    input  logic                    in_second,
    output logic                    can_load,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [55:0]             m_tdata,   // x[15:0], y[31:16], z[47:32], slot[50:48]
    output logic                    m_tlast
);

    logic                busy_reg;
    logic [2:0]          slot_reg;
    logic [2:0]          end_reg;
    stc_pkg::vtx_t [3:0] vtx_reg;
    stc_pkg::vtx_t       cur;
    logic                done;
    logic                load;

    assign done     = busy_reg && m_tready && (slot_reg == end_reg);
    assign can_load = !busy_reg || done;
    assign load     = in_valid && can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= stc_pkg::SLOT_A0;
            end_reg  <= stc_pkg::SLOT_B2;
        end else if (load) begin
            busy_reg <= 1'b1;
            slot_reg <= in_first ? stc_pkg::SLOT_A0 : stc_pkg::SLOT_B0;
            end_reg  <= in_second ? stc_pkg::SLOT_B2 : stc_pkg::SLOT_A2;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && m_tready) begin
            slot_reg <= slot_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vtx_reg <= in_vtx;
        end
    end

    // Triangle A is v0,v1,v3 and triangle B is v3,v2,v0
    always_comb begin
        case (slot_reg) inside
            stc_pkg::SLOT_A0, stc_pkg::SLOT_B2: cur = vtx_reg[0];
            stc_pkg::SLOT_A1:                   cur = vtx_reg[1];
            stc_pkg::SLOT_A2, stc_pkg::SLOT_B0: cur = vtx_reg[3];
            stc_pkg::SLOT_B1:                   cur = vtx_reg[2];
            default:                            cur = vtx_reg[0];
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = slot_reg == end_reg;
    assign m_tdata  = {5'd0, slot_reg, cur.z, cur.y, cur.x};

endmodule

### design/stc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the vertex output channel, bound to the top level.
// Depends on assert_macros.svh and stc_pkg.
`include "assert_macros.svh"

module stc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    `ASSERT_RST(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `ASSERT_RST(a_data_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "payload moved while stalled")
    `ASSERT_RST(a_slot_steps, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tdata[50:48] == $past(m_tdata[50:48]) + 3'd1), "vertex slot did not advance by one within a cell")
    `ASSERT_RST(a_final_slot, aclk, aresetn, m_tvalid && (m_tdata[50:48] == stc_pkg::SLOT_B2) |-> m_tlast, "closing slot of second triangle without tlast")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "output valid right after reset")

endmodule

bind sphere_cell_triangulator stc_checker u_stc_checker (.*);
